@@ rtl/core/integer_argument_parser_unit_macros.svh @@
// ---------------------------------------------------------------------------
// integer argument parser assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef INTEGER_ARGUMENT_PARSER_UNIT_MACROS_SVH
`define INTEGER_ARGUMENT_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define IAP_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("integer argument parser: same-cycle check failed");

// next-cycle implication
`define IAP_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("integer argument parser: next-cycle check failed");

`endif

@@ rtl/core/iap_pkg.sv @@
// ---------------------------------------------------------------------------
// iap_pkg
// parse phases, number bases, character codes and decode helpers
// ---------------------------------------------------------------------------
package iap_pkg;

  typedef enum logic [2:0] {
    PH_LEAD    = 3'd0,
    PH_MINUS   = 3'd1,
    PH_ZERO    = 3'd2,
    PH_PREFIX  = 3'd3,
    PH_NODIGWS = 3'd4,
    PH_DIGITS  = 3'd5,
    PH_TRAIL   = 3'd6,
    PH_GARBAGE = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_BIN = 2'd2,
    BASE_HEX = 2'd3
  } base_t;

  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SEVEN   = 8'h37;
  localparam logic [7:0] CH_EIGHT   = 8'h38;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_UPPER_B = 8'h42;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  localparam logic [4:0] NO_DIGIT = 5'd16;
  localparam logic [3:0] HEX_MAX_DIGITS = 4'd8;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // hex-style digit value, NO_DIGIT when not 0-9, a-f, A-F
  function automatic logic [4:0] char_digit(input logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      d = {1'b0, c[3:0]};
    end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) begin
      d = 5'(c - CH_LOWER_A) + 5'd10;
    end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) begin
      d = 5'(c - CH_UPPER_A) + 5'd10;
    end
    return d;
  endfunction

endpackage

@@ rtl/core/integer_argument_parser_unit.sv @@
// ---------------------------------------------------------------------------
// integer_argument_parser_unit
// c-style integer literal parser, one character per request
// ---------------------------------------------------------------------------
// Takes one character per cycle while in_ready is high, and an end marker
// closes the argument. Each accepted character updates the registered parse
// state; the end marker loads one result into the output register.
// in_ready drops only while that output register holds a result that is not
// being taken, so the block takes one request per cycle unless its output is
// stalled. Base prefixes 0x, 0b and leading-zero octal are recognized; values
// wrap modulo 2^32. default_value and default_enabled are to be written through
// the cfg port only while the block is idle; the block does not enforce this.
`include "integer_argument_parser_unit_macros.svh"

module integer_argument_parser_unit (
  input  logic               clk,
  input  logic               rst,
  // input characters
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  input  logic               is_end,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic               parse_error,
  output logic               used_default,
  // configuration
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [0:0] REG_DEFAULT_VALUE   = 1'd0;
  localparam logic [0:0] REG_DEFAULT_ENABLED = 1'd1;

  logic [31:0]      default_value;
  logic             default_enabled;

  iap_pkg::phase_t  phase, phase_next;
  iap_pkg::base_t   number_base, number_base_next;
  logic [31:0]      accumulator, accumulator_next;
  logic             is_negative, is_negative_next;
  logic [3:0]       hex_digit_count, hex_digit_count_next;

  logic             accept;
  logic             ws;
  logic [4:0]       digit;
  logic             digit_ok;
  logic [31:0]      acc_shifted;
  logic [31:0]      acc_step;
  logic [3:0]       hex_count_inc;
  logic [31:0]      result_value;
  logic             result_error;
  logic             result_default;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_value   <= '0;
      default_enabled <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEFAULT_VALUE:   default_value   <= cfg_data;
        REG_DEFAULT_ENABLED: default_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // character decode against the current base
  always_comb begin
    ws    = iap_pkg::is_space(char_code);
    digit = iap_pkg::char_digit(char_code);
    case (number_base)
      iap_pkg::BASE_DEC: digit_ok = digit < 5'd10;
      iap_pkg::BASE_OCT: digit_ok = digit < 5'd8;
      iap_pkg::BASE_BIN: digit_ok = digit < 5'd2;
      iap_pkg::BASE_HEX: digit_ok = (digit < iap_pkg::NO_DIGIT) &&
                                    (hex_digit_count < iap_pkg::HEX_MAX_DIGITS);
      default:           digit_ok = 1'b0;
    endcase
    case (number_base)
      iap_pkg::BASE_DEC: acc_shifted = (accumulator << 3) + (accumulator << 1);
      iap_pkg::BASE_OCT: acc_shifted = accumulator << 3;
      iap_pkg::BASE_BIN: acc_shifted = accumulator << 1;
      iap_pkg::BASE_HEX: acc_shifted = accumulator << 4;
      default:           acc_shifted = accumulator;
    endcase
    acc_step      = acc_shifted + {28'd0, digit[3:0]};
    hex_count_inc = (number_base == iap_pkg::BASE_HEX) ? hex_digit_count + 4'd1
                                                       : hex_digit_count;
  end

  // next parse state
  always_comb begin
    phase_next           = phase;
    number_base_next     = number_base;
    accumulator_next     = accumulator;
    is_negative_next     = is_negative;
    hex_digit_count_next = hex_digit_count;
    if (accept && is_end) begin
      phase_next           = iap_pkg::PH_LEAD;
      number_base_next     = iap_pkg::BASE_DEC;
      accumulator_next     = '0;
      is_negative_next     = 1'b0;
      hex_digit_count_next = '0;
    end else if (accept) begin
      case (phase)
        iap_pkg::PH_LEAD: begin
          if (ws) begin
            phase_next = iap_pkg::PH_LEAD;
          end else if (char_code == iap_pkg::CH_ZERO) begin
            phase_next = iap_pkg::PH_ZERO;
          end else if (char_code == iap_pkg::CH_MINUS) begin
            is_negative_next = 1'b1;
            phase_next       = iap_pkg::PH_MINUS;
          end else if (digit_ok) begin
            accumulator_next = acc_step;
            phase_next       = iap_pkg::PH_DIGITS;
          end else begin
            phase_next = iap_pkg::PH_GARBAGE;
          end
        end
        iap_pkg::PH_MINUS, iap_pkg::PH_DIGITS, iap_pkg::PH_PREFIX: begin
          if ((phase == iap_pkg::PH_PREFIX) && (number_base == iap_pkg::BASE_BIN) &&
              (char_code == iap_pkg::CH_MINUS)) begin
            is_negative_next = 1'b1;
            phase_next       = iap_pkg::PH_MINUS;
          end else if (digit_ok) begin
            accumulator_next     = acc_step;
            hex_digit_count_next = hex_count_inc;
            phase_next           = iap_pkg::PH_DIGITS;
          end else if (ws && (phase == iap_pkg::PH_DIGITS)) begin
            phase_next = iap_pkg::PH_TRAIL;
          end else if (ws && (phase == iap_pkg::PH_PREFIX)) begin
            phase_next = iap_pkg::PH_NODIGWS;
          end else begin
            phase_next = iap_pkg::PH_GARBAGE;
          end
        end
        iap_pkg::PH_ZERO: begin
          // accumulator is still zero here, so the digit is the new value
          if ((char_code == iap_pkg::CH_LOWER_X) || (char_code == iap_pkg::CH_UPPER_X)) begin
            number_base_next = iap_pkg::BASE_HEX;
            phase_next       = iap_pkg::PH_PREFIX;
          end else if ((char_code == iap_pkg::CH_LOWER_B) ||
                       (char_code == iap_pkg::CH_UPPER_B)) begin
            number_base_next = iap_pkg::BASE_BIN;
            phase_next       = iap_pkg::PH_PREFIX;
          end else if ((char_code == iap_pkg::CH_EIGHT) || (char_code == iap_pkg::CH_NINE)) begin
            number_base_next = iap_pkg::BASE_DEC;
            accumulator_next = {28'd0, char_code[3:0]};
            phase_next       = iap_pkg::PH_DIGITS;
          end else if ((char_code >= iap_pkg::CH_ZERO) && (char_code <= iap_pkg::CH_SEVEN)) begin
            number_base_next = iap_pkg::BASE_OCT;
            accumulator_next = {28'd0, char_code[3:0]};
            phase_next       = iap_pkg::PH_DIGITS;
          end else if (ws) begin
            phase_next = iap_pkg::PH_TRAIL;
          end else begin
            phase_next = iap_pkg::PH_GARBAGE;
          end
        end
        iap_pkg::PH_NODIGWS, iap_pkg::PH_TRAIL: begin
          if (!ws) begin
            phase_next = iap_pkg::PH_GARBAGE;
          end
        end
        default: begin
          phase_next = iap_pkg::PH_GARBAGE;
        end
      endcase
    end
  end

  // result of an end marker
  always_comb begin
    result_value   = '0;
    result_error   = 1'b0;
    result_default = 1'b0;
    case (phase)
      iap_pkg::PH_LEAD: begin
        if (default_enabled) begin
          result_value   = default_value;
          result_default = 1'b1;
        end else begin
          result_error = 1'b1;
        end
      end
      iap_pkg::PH_PREFIX, iap_pkg::PH_NODIGWS: begin
        result_error = 1'b1;
      end
      iap_pkg::PH_ZERO, iap_pkg::PH_DIGITS, iap_pkg::PH_TRAIL: begin
        result_value = is_negative ? (32'd0 - accumulator) : accumulator;
      end
      default: begin
        // trailing garbage, including a sign with no digits
        result_value = '1;
        result_error = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= iap_pkg::PH_LEAD;
      number_base     <= iap_pkg::BASE_DEC;
      accumulator     <= '0;
      is_negative     <= 1'b0;
      hex_digit_count <= '0;
      out_valid       <= 1'b0;
    end else begin
      phase           <= phase_next;
      number_base     <= number_base_next;
      accumulator     <= accumulator_next;
      is_negative     <= is_negative_next;
      hex_digit_count <= hex_digit_count_next;
      if (accept && is_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_end) begin
      value        <= result_value;
      parse_error  <= result_error;
      used_default <= result_default;
    end
  end

  `IAP_ASSERT_NEXT(a_end_gives_result, clk, rst, accept && is_end, out_valid)
  `IAP_ASSERT_NEXT(a_end_clears_state, clk, rst, accept && is_end,
                   (phase == iap_pkg::PH_LEAD) && (accumulator == 32'd0))
  `IAP_ASSERT_SAME(a_default_no_error, clk, rst, out_valid && used_default, !parse_error)
  `IAP_ASSERT_SAME(a_error_value, clk, rst, out_valid && parse_error,
                   (value == 32'sd0) || (value == -32'sd1))

endmodule

@@ tb/integer_argument_parser_unit_test.sv @@
// ---------------------------------------------------------------------------
// integer_argument_parser_unit_test
// self-checking bench for the c-style integer argument parser
// ---------------------------------------------------------------------------
// Sends arguments one character per request, closed by an end marker, and
// tracks the parse in a local model to predict each result. Directed strings
// cover the base prefixes, signs, wrap, lone zero, empty and garbage cases.
// Random arguments are mostly well-formed literals with random digits, mixed
// with noise bytes and corrupted text. Idle cycles fall on either side, and a
// long output stall fills the block.
`timescale 1ns / 1ps

module integer_argument_parser_unit_test;

  localparam logic [0:0] CFG_DEFAULT_VALUE   = 1'b0;
  localparam logic [0:0] CFG_DEFAULT_ENABLED = 1'b1;

  typedef struct {
    logic signed [31:0] value;
    logic               parse_error;
    logic               used_default;
  } parse_result_t;

  typedef logic [7:0] text_t [$];

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         char_code = 8'h00;
  logic               is_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] value;
  logic               parse_error;
  logic               used_default;
  logic               cfg_write = 1'b0;
  logic [0:0]         cfg_index = 1'b0;
  logic [31:0]        cfg_data = 32'h0;

  integer_argument_parser_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .is_end       (is_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .parse_error  (parse_error),
    .used_default (used_default),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // shared bookkeeping
  parse_result_t pending_results [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles_req = 0;
  int fail_count = 0;
  int chars_sent = 0;
  int args_sent = 0;
  int results_checked = 0;

  // local copy of the parser state and registers
  logic [31:0]       cfg_dflt_value = 32'h0;
  logic              cfg_dflt_en = 1'b0;
  iap_pkg::phase_t   ps_phase = iap_pkg::PH_LEAD;
  logic [31:0]       ps_acc = 32'h0;
  iap_pkg::base_t    ps_base = iap_pkg::BASE_DEC;
  logic              ps_neg = 1'b0;
  logic [3:0]        ps_hex_count = 4'd0;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == iap_pkg::CH_SPACE) || ((c >= iap_pkg::CH_TAB) && (c <= iap_pkg::CH_CR));
  endfunction

  // digit value in the current base, NO_DIGIT otherwise
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [4:0] d;
    d = iap_pkg::NO_DIGIT;
    if ((c >= iap_pkg::CH_ZERO) && (c <= iap_pkg::CH_NINE)) begin
      d = 5'(c - iap_pkg::CH_ZERO);
    end else if ((c >= iap_pkg::CH_LOWER_A) && (c <= iap_pkg::CH_LOWER_F)) begin
      d = 5'(c - iap_pkg::CH_LOWER_A) + 5'd10;
    end else if ((c >= iap_pkg::CH_UPPER_A) && (c <= iap_pkg::CH_UPPER_F)) begin
      d = 5'(c - iap_pkg::CH_UPPER_A) + 5'd10;
    end
    case (ps_base)
      iap_pkg::BASE_DEC: if (d >= 5'd10) d = iap_pkg::NO_DIGIT;
      iap_pkg::BASE_OCT: if (d >= 5'd8) d = iap_pkg::NO_DIGIT;
      iap_pkg::BASE_BIN: if (d >= 5'd2) d = iap_pkg::NO_DIGIT;
      default: begin
        if (d >= 5'd16 || ps_hex_count >= iap_pkg::HEX_MAX_DIGITS) d = iap_pkg::NO_DIGIT;
      end
    endcase
    return d;
  endfunction

  task automatic take_digit(input logic [4:0] d);
    case (ps_base)
      iap_pkg::BASE_DEC: ps_acc = ps_acc * 32'd10 + 32'(d);
      iap_pkg::BASE_OCT: ps_acc = (ps_acc << 3) + 32'(d);
      iap_pkg::BASE_BIN: ps_acc = (ps_acc << 1) + 32'(d);
      default: begin
        ps_acc = (ps_acc << 4) | 32'(d);
        ps_hex_count = ps_hex_count + 4'd1;
      end
    endcase
    ps_phase = iap_pkg::PH_DIGITS;
  endtask

  // advance the parse by one accepted request, queue a result on end marker
  task automatic advance_parse(input logic [7:0] c, input logic e);
    logic [4:0]    d;
    parse_result_t r;
    if (!e) begin
      d = digit_value(c);
      case (ps_phase)
        iap_pkg::PH_LEAD: begin
          if (!is_blank(c)) begin
            if (c == iap_pkg::CH_ZERO) ps_phase = iap_pkg::PH_ZERO;
            else if (c == iap_pkg::CH_MINUS) begin
              ps_neg = 1'b1;
              ps_phase = iap_pkg::PH_MINUS;
            end else if (d != iap_pkg::NO_DIGIT) take_digit(d);
            else ps_phase = iap_pkg::PH_GARBAGE;
          end
        end
        iap_pkg::PH_MINUS: begin
          if (d != iap_pkg::NO_DIGIT) take_digit(d);
          else ps_phase = iap_pkg::PH_GARBAGE;
        end
        iap_pkg::PH_ZERO: begin
          if (c == iap_pkg::CH_LOWER_X || c == iap_pkg::CH_UPPER_X) begin
            ps_base = iap_pkg::BASE_HEX;
            ps_phase = iap_pkg::PH_PREFIX;
          end else if (c == iap_pkg::CH_LOWER_B || c == iap_pkg::CH_UPPER_B) begin
            ps_base = iap_pkg::BASE_BIN;
            ps_phase = iap_pkg::PH_PREFIX;
          end else if (c == iap_pkg::CH_EIGHT || c == iap_pkg::CH_NINE) begin
            ps_base = iap_pkg::BASE_DEC;
            take_digit(5'(c - iap_pkg::CH_ZERO));
          end else if (c >= iap_pkg::CH_ZERO && c <= iap_pkg::CH_SEVEN) begin
            ps_base = iap_pkg::BASE_OCT;
            take_digit(5'(c - iap_pkg::CH_ZERO));
          end else if (is_blank(c)) ps_phase = iap_pkg::PH_TRAIL;
          else ps_phase = iap_pkg::PH_GARBAGE;
        end
        iap_pkg::PH_PREFIX: begin
          if (ps_base == iap_pkg::BASE_BIN && c == iap_pkg::CH_MINUS) begin
            ps_neg = 1'b1;
            ps_phase = iap_pkg::PH_MINUS;
          end else if (d != iap_pkg::NO_DIGIT) take_digit(d);
          else if (is_blank(c)) ps_phase = iap_pkg::PH_NODIGWS;
          else ps_phase = iap_pkg::PH_GARBAGE;
        end
        iap_pkg::PH_DIGITS: begin
          if (d != iap_pkg::NO_DIGIT) take_digit(d);
          else if (is_blank(c)) ps_phase = iap_pkg::PH_TRAIL;
          else ps_phase = iap_pkg::PH_GARBAGE;
        end
        iap_pkg::PH_NODIGWS, iap_pkg::PH_TRAIL: begin
          if (!is_blank(c)) ps_phase = iap_pkg::PH_GARBAGE;
        end
        default: ps_phase = iap_pkg::PH_GARBAGE;
      endcase
    end else begin
      r.value = 32'sd0;
      r.parse_error = 1'b0;
      r.used_default = 1'b0;
      case (ps_phase)
        iap_pkg::PH_LEAD: begin
          if (cfg_dflt_en) begin
            r.value = cfg_dflt_value;
            r.used_default = 1'b1;
          end else r.parse_error = 1'b1;
        end
        iap_pkg::PH_PREFIX, iap_pkg::PH_NODIGWS: r.parse_error = 1'b1;
        iap_pkg::PH_ZERO, iap_pkg::PH_DIGITS, iap_pkg::PH_TRAIL: begin
          r.value = ps_neg ? (32'h0 - ps_acc) : ps_acc;
        end
        default: begin
          r.value = -32'sd1;
          r.parse_error = 1'b1;
        end
      endcase
      pending_results.push_back(r);
      ps_phase = iap_pkg::PH_LEAD;
      ps_acc = 32'h0;
      ps_base = iap_pkg::BASE_DEC;
      ps_neg = 1'b0;
      ps_hex_count = 4'd0;
    end
  endtask

  // one request; valid stays up between back-to-back requests
  task automatic send_char(input logic [7:0] c, input logic e);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      char_code <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    is_end <= e;
    do @(posedge clk); while (!in_ready);
    advance_parse(c, e);
    chars_sent++;
  endtask

  task automatic send_arg(input text_t t);
    foreach (t[i]) send_char(t[i], 1'b0);
    send_char(8'($urandom_range(255)), 1'b1);
    args_sent++;
  endtask

  task automatic send_text(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_arg(t);
  endtask

  // stop sending and let every queued result come out
  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [0:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_DEFAULT_VALUE) cfg_dflt_value = data;
    else cfg_dflt_en = data[0];
  endtask

  function automatic logic [7:0] rand_blank();
    int k;
    k = $urandom_range(5);
    return (k == 5) ? iap_pkg::CH_SPACE : iap_pkg::CH_TAB + 8'(k);
  endfunction

  function automatic logic [7:0] rand_digit(input iap_pkg::base_t b);
    int k;
    case (b)
      iap_pkg::BASE_DEC: return iap_pkg::CH_ZERO + 8'($urandom_range(9));
      iap_pkg::BASE_OCT: return iap_pkg::CH_ZERO + 8'($urandom_range(7));
      iap_pkg::BASE_BIN: return iap_pkg::CH_ZERO + 8'($urandom_range(1));
      default: begin
        k = $urandom_range(21);
        if (k < 10) return iap_pkg::CH_ZERO + 8'(k);
        else if (k < 16) return iap_pkg::CH_LOWER_A + 8'(k - 10);
        else return iap_pkg::CH_UPPER_A + 8'(k - 16);
      end
    endcase
  endfunction

  // mostly well-formed literals, some noise and broken text
  task automatic build_arg(output text_t t);
    int kind;
    int n;
    t = {};
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(2)) t.push_back(rand_blank());
    if (kind < 28) begin
      if ($urandom_range(3) == 0) t.push_back(iap_pkg::CH_MINUS);
      t.push_back(iap_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
      repeat ($urandom_range(11)) t.push_back(rand_digit(iap_pkg::BASE_DEC));
    end else if (kind < 46) begin
      t.push_back(iap_pkg::CH_ZERO);
      t.push_back($urandom_range(1) ? iap_pkg::CH_LOWER_X : iap_pkg::CH_UPPER_X);
      n = ($urandom_range(9) == 0) ? 9 : $urandom_range(1, 8);
      repeat (n) t.push_back(rand_digit(iap_pkg::BASE_HEX));
    end else if (kind < 60) begin
      t.push_back(iap_pkg::CH_ZERO);
      t.push_back($urandom_range(1) ? iap_pkg::CH_LOWER_B : iap_pkg::CH_UPPER_B);
      if ($urandom_range(2) == 0) t.push_back(iap_pkg::CH_MINUS);
      repeat ($urandom_range(1, 34)) t.push_back(rand_digit(iap_pkg::BASE_BIN));
    end else if (kind < 72) begin
      t.push_back(iap_pkg::CH_ZERO);
      repeat ($urandom_range(1, 12)) t.push_back(rand_digit(iap_pkg::BASE_OCT));
    end else if (kind < 78) begin
      t.push_back(iap_pkg::CH_ZERO);
      t.push_back($urandom_range(1) ? iap_pkg::CH_EIGHT : iap_pkg::CH_NINE);
      repeat ($urandom_range(9)) t.push_back(rand_digit(iap_pkg::BASE_DEC));
    end else if (kind < 84) begin
      t.push_back(iap_pkg::CH_ZERO);
    end else if (kind < 89) begin
      // empty argument, blanks at most
    end else if (kind < 93) begin
      t.push_back(iap_pkg::CH_ZERO);
      case ($urandom_range(3))
        0: t.push_back(iap_pkg::CH_LOWER_X);
        1: t.push_back(iap_pkg::CH_UPPER_X);
        2: t.push_back(iap_pkg::CH_LOWER_B);
        default: t.push_back(iap_pkg::CH_UPPER_B);
      endcase
    end else if (kind < 96) begin
      if ($urandom_range(1)) begin
        t.push_back(iap_pkg::CH_ZERO);
        t.push_back(iap_pkg::CH_LOWER_B);
      end
      t.push_back(iap_pkg::CH_MINUS);
    end else begin
      t.push_back(iap_pkg::CH_ZERO);
      t.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) t.push_back(rand_blank());
    if ($urandom_range(9) == 0 && t.size() > 0) begin
      t[$urandom_range(t.size() - 1)] = 8'($urandom_range(255));
    end else if ($urandom_range(19) == 0) begin
      t.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic run_random_args(input int char_budget, input int sidle, input int ridle);
    text_t t;
    int    start;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    start = chars_sent;
    while (chars_sent - start < char_budget) begin
      build_arg(t);
      send_arg(t);
      // sender pause until the block has emptied
      if ($urandom_range(24) == 0) wait_results();
    end
    wait_results();
  endtask

  task automatic test_directed_cases();
    string cases [$] = {"", "0", "  0  ", "0x", "0X  ", "0xFFFFFFFF", "0x123456789",
                        "0xdeadBEEF", "0b-101", "0B11111111111111111111111111111111",
                        "-", "-2147483648", "4294967297", "0777", "08", "-09", "0z",
                        "0 z", "12a", "0b2", "0b", "\t42\n", "0b-", "\v-0 \f"};
    send_idle_pct = 10;
    recv_idle_pct = 10;
    foreach (cases[i]) send_text(cases[i]);
    wait_results();
    write_register(CFG_DEFAULT_ENABLED, 32'h1);
    write_register(CFG_DEFAULT_VALUE, 32'h7FFF_FFFF);
    send_text("");
    send_text("  \t");
    wait_results();
    write_register(CFG_DEFAULT_VALUE, 32'h8000_0000);
    send_text("");
    send_text("x");
    wait_results();
  endtask

  task automatic test_sender_gaps();
    write_register(CFG_DEFAULT_ENABLED, 32'h0);
    write_register(CFG_DEFAULT_VALUE, 32'h0);
    run_random_args(310, 19, 63);
  endtask

  task automatic test_receiver_gaps();
    write_register(CFG_DEFAULT_VALUE, 32'($urandom));
    write_register(CFG_DEFAULT_ENABLED, 32'h1);
    run_random_args(310, 63, 19);
  endtask

  task automatic test_full_rate();
    write_register(CFG_DEFAULT_VALUE, 32'hFFFF_FFFF);
    run_random_args(310, 0, 0);
  endtask

  // receiver holds off while arguments keep coming, input must stall
  task automatic test_output_stall();
    text_t t;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles_req = 200;
    repeat (30) begin
      build_arg(t);
      send_arg(t);
    end
    wait_results();
  endtask

  // receiver side: random idling plus a requested long hold-off
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_cycles_req > 0) begin
      hold_left = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    parse_result_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result value %0d error %0b default %0b",
                 $time, value, parse_error, used_default);
      end else begin
        w = pending_results.pop_front();
        results_checked++;
        if (value !== w.value) begin
          fail_count++;
          $display("%0t: value mismatch: expected %0d, actual %0d", $time, w.value, value);
        end
        if (parse_error !== w.parse_error) begin
          fail_count++;
          $display("%0t: parse_error mismatch: expected %0b, actual %0b",
                   $time, w.parse_error, parse_error);
        end
        if (used_default !== w.used_default) begin
          fail_count++;
          $display("%0t: used_default mismatch: expected %0b, actual %0b",
                   $time, w.used_default, used_default);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("integer_argument_parser_unit_test NOT OK");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_sender_gaps();
    test_receiver_gaps();
    test_full_rate();
    test_output_stall();
    wait_results();
    $display("covered %0d arguments in %0d requests, %0d results checked",
             args_sent, chars_sent, results_checked);
    $display("bases, signs, wrap, defaults, garbage, idle gaps and a long output stall");
    if (fail_count == 0) begin
      $display("integer_argument_parser_unit_test OK");
    end else begin
      $display("integer_argument_parser_unit_test NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/iap_pkg.sv
rtl/core/integer_argument_parser_unit.sv
tb/integer_argument_parser_unit_test.sv
